FILE: rtl/kgf_pkg.sv
package kgf_pkg;

  localparam int SignalWidthDef = 32;
  localparam int CovFracBitsDef = 28;

  localparam int CfgAddrW = 4;

  localparam logic [1:0] REG_Q_ANGLE = 2'd0;
  localparam logic [1:0] REG_Q_BIAS  = 2'd1;
  localparam logic [1:0] REG_R_MEAS  = 2'd2;
  localparam logic [1:0] REG_DT      = 2'd3;

  localparam logic [31:0] Q_ANGLE_RST = 32'd4294967;
  localparam logic [31:0] Q_BIAS_RST  = 32'd12884902;
  localparam logic [31:0] R_MEAS_RST  = 32'd2147483648;
  localparam logic [31:0] DT_RST      = 32'd5368709;

  // datapath steps, each one multiply and its write back
  localparam int OpW = 4;
  localparam logic [OpW-1:0] OP_ANGLE_PRED = 4'd0;
  localparam logic [OpW-1:0] OP_C00_PRED   = 4'd1;
  localparam logic [OpW-1:0] OP_C01_PRED   = 4'd2;
  localparam logic [OpW-1:0] OP_C11_PRED   = 4'd3;
  localparam logic [OpW-1:0] OP_C10_CORR   = 4'd4;
  localparam logic [OpW-1:0] OP_C11_CORR   = 4'd5;
  localparam logic [OpW-1:0] OP_C00_CORR   = 4'd6;
  localparam logic [OpW-1:0] OP_C01_CORR   = 4'd7;
  localparam logic [OpW-1:0] OP_ANGLE_CORR = 4'd8;
  localparam logic [OpW-1:0] OP_BIAS_CORR  = 4'd9;

  typedef struct packed {
    logic signed [31:0] angle_meas;
    logic signed [31:0] rate_meas;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] angle_est;
    logic signed [31:0] rate_est;
  } out_beat_t;

  typedef struct packed {
    logic           load;
    logic           mul_start;
    logic           mul_wb;
    logic           div_start;
    logic           div_wb;
    logic           div_sel;
    logic           emit;
    logic [OpW-1:0] op;
  } cmd_t;

  typedef struct packed {
    logic mul_done;
    logic div_done;
  } status_t;

endpackage

FILE: rtl/kgf_mul.sv
module kgf_mul #(
  parameter int DW   = 34,
  parameter int FRAC = 28
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         frac_i,
  input  logic signed [DW-1:0]         a_i,
  input  logic signed [DW-1:0]         b_i,
  output logic                         done_o,
  output logic signed [2*DW:0]         res_o
);
  localparam int PW = 2 * DW;
  localparam int CW = $clog2(DW + 1);
  localparam logic [PW:0] RndF  = (PW+1)'(1) << (FRAC - 1);
  localparam logic [PW:0] Rnd32 = (PW+1)'(1) << 31;

  logic [DW-1:0] xm_q, ym_q;
  logic [PW-1:0] acc_q;
  logic          neg_q, frac_q, done_q;
  logic [CW-1:0] cnt_q;
  logic [PW:0]   rnd, shd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CW'(DW);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - CW'(1);
      done_q <= (cnt_q == CW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  // shift-add over the multiplier magnitude, MSB first
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      xm_q   <= a_i[DW-1] ? DW'(-a_i) : DW'(a_i);
      ym_q   <= b_i[DW-1] ? DW'(-b_i) : DW'(b_i);
      neg_q  <= a_i[DW-1] ^ b_i[DW-1];
      frac_q <= frac_i;
      acc_q  <= '0;
    end else if (cnt_q != '0) begin
      acc_q <= {acc_q[PW-2:0], 1'b0} + (ym_q[DW-1] ? PW'(xm_q) : '0);
      ym_q  <= {ym_q[DW-2:0], 1'b0};
    end
  end

  // round half away from zero on the magnitude
  assign rnd    = {1'b0, acc_q} + (frac_q ? RndF : Rnd32);
  assign shd    = frac_q ? (rnd >> FRAC) : (rnd >> 32);
  assign res_o  = neg_q ? -$signed({1'b0, shd[PW-1:0]}) : $signed({1'b0, shd[PW-1:0]});
  assign done_o = done_q;

endmodule

FILE: rtl/kgf_div.sv
module kgf_div #(
  parameter int FRAC = 28
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] num_i,
  input  logic [31:0]        den_i,
  output logic               done_o,
  output logic signed [31:0] quo_o
);
  localparam int NW = 32 + FRAC;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] num_q, quo_q;
  logic [32:0]   rem_q, rem_sh;
  logic [31:0]   den_q, nmag;
  logic          neg_q, done_q, fits;
  logic [CW-1:0] cnt_q;

  assign nmag   = num_i[31] ? 32'(-num_i) : 32'(num_i);
  assign rem_sh = {rem_q[31:0], num_q[NW-1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CW'(NW);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - CW'(1);
      done_q <= (cnt_q == CW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= {nmag, {FRAC{1'b0}}};
      den_q <= den_i;
      neg_q <= num_i[31];
      rem_q <= '0;
      quo_q <= '0;
    end else if (cnt_q != '0) begin
      num_q <= {num_q[NW-2:0], 1'b0};
      if (rem_sh >= {1'b0, den_q}) begin
        rem_q <= rem_sh - {1'b0, den_q};
        quo_q <= {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[NW-2:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (neg_q) begin
      fits  = (quo_q[NW-1:32] == '0) && !(quo_q[31] && (quo_q[30:0] != '0));
      quo_o = fits ? $signed(-quo_q[31:0]) : $signed({1'b1, 31'd0});
    end else begin
      fits  = (quo_q[NW-1:31] == '0);
      quo_o = fits ? $signed(quo_q[31:0]) : $signed({1'b0, {31{1'b1}}});
    end
  end

  assign done_o = done_q;

endmodule

FILE: rtl/kgf_datapath.sv
module kgf_datapath #(
  parameter int SW   = 32,
  parameter int FRAC = 28
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kgf_pkg::cmd_t      cmd_i,
  output kgf_pkg::status_t   status_o,
  input  kgf_pkg::in_beat_t  in_data_i,
  input  logic [31:0]        q_angle_i,
  input  logic [31:0]        q_bias_i,
  input  logic [31:0]        r_meas_i,
  input  logic [31:0]        dt_i,
  output kgf_pkg::out_beat_t out_data_o
);
  import kgf_pkg::*;

  localparam int DW = ((SW > 32) ? SW : 32) + 2;
  localparam int PW = 2 * DW;
  localparam int RW = PW + 1;
  localparam int AW = PW + 2;
  localparam int SH = 32 - FRAC;
  localparam logic signed [AW-1:0] SwMax  = {{(AW-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [AW-1:0] SwMin  = ~SwMax;
  localparam logic signed [AW-1:0] C32Max = {{(AW-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [AW-1:0] C32Min = ~C32Max;
  localparam logic signed [31:0]   CovOne = 32'sd1 <<< FRAC;

  function automatic logic [31:0] to_cov(input logic [31:0] q);
    logic [32:0] t;
    t = {1'b0, q} + (33'd1 << (SH - 1));
    return 32'(t >> SH);
  endfunction

  function automatic logic signed [SW-1:0] sat_sw(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] r;
    r = v;
    if (v > SwMax) r = SwMax;
    if (v < SwMin) r = SwMin;
    return r[SW-1:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] r;
    r = v;
    if (v > C32Max) r = C32Max;
    if (v < C32Min) r = C32Min;
    return r[31:0];
  endfunction

  logic signed [SW-1:0] angle_q, bias_q;
  logic signed [31:0]   c00_q, c01_q, c10_q, c11_q, k0_q, k1_q, am_q, rm_q;
  logic signed [DW-1:0] err_q, op_a, op_b, rm_bias, err_now;
  logic                 op_frac;
  logic signed [RW-1:0] prod;
  logic signed [31:0]   quo, div_num;
  logic signed [33:0]   innov;
  logic                 innov_pos;
  logic                 mul_done, div_done;
  out_beat_t            out_q;

  assign rm_bias   = DW'(rm_q) - DW'(bias_q);
  assign err_now   = DW'(am_q) - DW'(angle_q);
  assign innov     = $signed({2'b00, to_cov(r_meas_i)}) + 34'(c00_q);
  assign innov_pos = !innov[33] && (innov != '0);
  assign div_num   = cmd_i.div_sel ? c10_q : c00_q;

  always_comb begin
    op_frac = 1'b1;
    op_a    = '0;
    op_b    = '0;
    unique case (cmd_i.op)
      OP_ANGLE_PRED: begin
        op_frac = 1'b0;
        op_a    = rm_bias;
        op_b    = $signed(DW'(dt_i));
      end
      OP_C00_PRED: begin
        op_frac = 1'b0;
        op_a    = $signed(DW'(to_cov(q_angle_i))) - DW'(c01_q) - DW'(c10_q);
        op_b    = $signed(DW'(dt_i));
      end
      OP_C01_PRED: begin
        op_frac = 1'b0;
        op_a    = -DW'(c11_q);
        op_b    = $signed(DW'(dt_i));
      end
      OP_C11_PRED: begin
        op_frac = 1'b0;
        op_a    = $signed(DW'(to_cov(q_bias_i)));
        op_b    = $signed(DW'(dt_i));
      end
      OP_C10_CORR: begin
        op_a = DW'(k1_q);
        op_b = DW'(c00_q);
      end
      OP_C11_CORR: begin
        op_a = DW'(k1_q);
        op_b = DW'(c01_q);
      end
      OP_C00_CORR: begin
        op_a = DW'(k0_q);
        op_b = DW'(c00_q);
      end
      OP_C01_CORR: begin
        op_a = DW'(k0_q);
        op_b = DW'(c01_q);
      end
      OP_ANGLE_CORR: begin
        op_a = DW'(k0_q);
        op_b = err_q;
      end
      OP_BIAS_CORR: begin
        op_a = DW'(k1_q);
        op_b = err_q;
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  kgf_mul #(.DW(DW), .FRAC(FRAC)) u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .frac_i  (op_frac),
    .a_i     (op_a),
    .b_i     (op_b),
    .done_o  (mul_done),
    .res_o   (prod)
  );

  kgf_div #(.FRAC(FRAC)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .num_i   (div_num),
    .den_i   (innov[31:0]),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign status_o = '{mul_done: mul_done, div_done: div_done};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      angle_q <= '0;
      bias_q  <= '0;
      c00_q   <= CovOne;
      c01_q   <= '0;
      c10_q   <= '0;
      c11_q   <= CovOne;
    end else if (cmd_i.mul_wb) begin
      case (cmd_i.op)
        OP_ANGLE_PRED: angle_q <= sat_sw(AW'(angle_q) + AW'(prod));
        OP_C00_PRED:   c00_q   <= sat32(AW'(c00_q) + AW'(prod));
        OP_C01_PRED: begin
          c01_q <= sat32(AW'(c01_q) + AW'(prod));
          c10_q <= sat32(AW'(c10_q) + AW'(prod));
        end
        OP_C11_PRED:   c11_q   <= sat32(AW'(c11_q) + AW'(prod));
        OP_C10_CORR:   c10_q   <= sat32(AW'(c10_q) - AW'(prod));
        OP_C11_CORR:   c11_q   <= sat32(AW'(c11_q) - AW'(prod));
        OP_C00_CORR:   c00_q   <= sat32(AW'(c00_q) - AW'(prod));
        OP_C01_CORR:   c01_q   <= sat32(AW'(c01_q) - AW'(prod));
        OP_ANGLE_CORR: angle_q <= sat_sw(AW'(angle_q) + AW'(prod));
        OP_BIAS_CORR:  bias_q  <= sat_sw(AW'(bias_q) + AW'(prod));
        default:       angle_q <= angle_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      am_q <= in_data_i.angle_meas;
      rm_q <= in_data_i.rate_meas;
    end
    // latch the innovation once the prediction is done
    if (cmd_i.div_start && !cmd_i.div_sel) begin
      err_q <= err_now;
    end
    if (cmd_i.div_wb) begin
      if (cmd_i.div_sel) begin
        k1_q <= innov_pos ? quo : '0;
      end else begin
        k0_q <= innov_pos ? quo : '0;
      end
    end
    if (cmd_i.emit) begin
      out_q.angle_est <= sat32(AW'(angle_q));
      out_q.rate_est  <= sat32(AW'(sat_sw(AW'(rm_bias))));
    end
  end

  assign out_data_o = out_q;

endmodule

FILE: rtl/kgf_ctrl.sv
module kgf_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  input  kgf_pkg::status_t status_i,
  output kgf_pkg::cmd_t    cmd_o
);
  import kgf_pkg::*;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_MUL_GO   = 3'd1;
  localparam logic [2:0] ST_MUL_WAIT = 3'd2;
  localparam logic [2:0] ST_DIV_GO   = 3'd3;
  localparam logic [2:0] ST_DIV_WAIT = 3'd4;
  localparam logic [2:0] ST_OUT      = 3'd5;

  logic [2:0]     state_q, state_d;
  logic [OpW-1:0] op_q, op_d;
  logic           sel_q, sel_d;
  logic           out_valid_q, out_valid_d;
  cmd_t           cmd;

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    sel_d       = sel_q;
    cmd         = '0;
    cmd.op      = op_q;
    cmd.div_sel = sel_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd.load = 1'b1;
          op_d     = OP_ANGLE_PRED;
          state_d  = ST_MUL_GO;
        end
      end
      ST_MUL_GO: begin
        cmd.mul_start = 1'b1;
        state_d       = ST_MUL_WAIT;
      end
      ST_MUL_WAIT: begin
        if (status_i.mul_done) begin
          cmd.mul_wb = 1'b1;
          if (op_q == OP_C11_PRED) begin
            sel_d   = 1'b0;
            state_d = ST_DIV_GO;
          end else if (op_q == OP_BIAS_CORR) begin
            state_d = ST_OUT;
          end else begin
            op_d    = op_q + OpW'(1);
            state_d = ST_MUL_GO;
          end
        end
      end
      ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_d       = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (status_i.div_done) begin
          cmd.div_wb = 1'b1;
          if (!sel_q) begin
            sel_d   = 1'b1;
            state_d = ST_DIV_GO;
          end else begin
            op_d    = OP_C10_CORR;
            state_d = ST_MUL_GO;
          end
        end
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!out_valid_q || !out_stall_i) begin
          cmd.emit = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_d = cmd.emit || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      op_q        <= OP_ANGLE_PRED;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      op_q        <= op_d;
      sel_q       <= sel_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign cmd_o       = cmd;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: rtl/angle_gyro_kalman_filter.sv
// A beat is worked through the bit-serial multiplier and divider; in_stall_o stays high until
//   its result is in the output register, so no new beat is taken before then.
// A result waiting in the output register does not block the next input beat.
// Reset: asynchronous, active low; state clears, covariance goes to identity,
//   tuning registers take their defaults. No clearing pass.
module angle_gyro_kalman_filter #(
  parameter int SIGNAL_WIDTH  = kgf_pkg::SignalWidthDef,
  parameter int COV_FRAC_BITS = kgf_pkg::CovFracBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  kgf_pkg::in_beat_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output kgf_pkg::out_beat_t            out_data_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [kgf_pkg::CfgAddrW-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import kgf_pkg::*;

  logic [31:0]  q_angle_q, q_bias_q, r_meas_q, dt_q;
  logic [1:0]   reg_idx;
  logic         cfg_wr;
  cmd_t         cmd;
  status_t      status;

  // Register map: word index from paddr[3:2]; all four words are writable.
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      q_angle_q <= Q_ANGLE_RST;
      q_bias_q  <= Q_BIAS_RST;
      r_meas_q  <= R_MEAS_RST;
      dt_q      <= DT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_Q_ANGLE: q_angle_q <= pwdata;
        REG_Q_BIAS:  q_bias_q  <= pwdata;
        REG_R_MEAS:  r_meas_q  <= pwdata;
        REG_DT:      dt_q      <= pwdata;
        default:     dt_q      <= dt_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_Q_ANGLE: prdata = q_angle_q;
      REG_Q_BIAS:  prdata = q_bias_q;
      REG_R_MEAS:  prdata = r_meas_q;
      REG_DT:      prdata = dt_q;
      default:     prdata = '0;
    endcase
  end

  // Sequencer: predict (four multiplies), two gain divisions, then six
  // correction multiplies, then one result beat into the output register.
  kgf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // Filter state, operand selection, shared multiplier and divider.
  kgf_datapath #(
    .SW   (SIGNAL_WIDTH),
    .FRAC (COV_FRAC_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .status_o   (status),
    .in_data_i  (in_data_i),
    .q_angle_i  (q_angle_q),
    .q_bias_i   (q_bias_q),
    .r_meas_i   (r_meas_q),
    .dt_i       (dt_q),
    .out_data_o (out_data_o)
  );

  // An accepted beat keeps the block busy on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted while not going busy");

  // Never overwrite a result that is still waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !(out_valid_o && out_stall_i))
    else $error("result overwritten while stalled");

  // Multiplier and divider are never launched together.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.mul_start && cmd.div_start))
    else $error("multiply and divide started together");

endmodule
